/* rtl/cidt_pkg.sv */
package cidt_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // Request types
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_BIND   = 1'b1;

    // Entry kinds
    localparam logic KIND_RASTER = 1'b0;

    // Ordinal code of an entry that has no bound record yet
    localparam logic [7:0] ORDINAL_UNSET = 8'hFF;

    // Configuration register
    localparam int         CAP_W     = 7;
    localparam logic [6:0] CAP_RESET = 7'd64;

    // One stored identity
    typedef struct packed {
        logic        kind;
        logic [63:0] hash;
        logic [31:0] crc;
        logic [63:0] size;
    } ident_t;

    // Access command from the sequencer to the entry memories
    typedef struct packed {
        logic [7:0] rd_addr;
        logic [7:0] wr_addr;
        logic       id_we;
        logic       ord_we;
        ident_t     id_wdata;
        logic [7:0] ord_wdata;
    } store_cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0] status;
        logic       was_hit;
        logic [5:0] found_index;
        logic [5:0] canonical_record;
    } result_t;

endpackage

/* rtl/cidt_store.sv */
module cidt_store #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                clk,
    input  cidt_pkg::store_cmd_t cmd,
    output cidt_pkg::ident_t    id_rdata_reg,
    output logic [7:0]          ord_rdata_reg
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    cidt_pkg::ident_t id_mem  [TABLE_DEPTH];
    logic [7:0]       ord_mem [TABLE_DEPTH];

    // Identity memory: kind, hash, CRC, size
    always_ff @(posedge clk)
    begin
        if (cmd.id_we)
        begin
            id_mem[cmd.wr_addr[IDX_W-1:0]] <= cmd.id_wdata;
        end
        id_rdata_reg <= id_mem[cmd.rd_addr[IDX_W-1:0]];
    end

    // Ordinal memory
    always_ff @(posedge clk)
    begin
        if (cmd.ord_we)
        begin
            ord_mem[cmd.wr_addr[IDX_W-1:0]] <= cmd.ord_wdata;
        end
        ord_rdata_reg <= ord_mem[cmd.rd_addr[IDX_W-1:0]];
    end

endmodule

/* rtl/cidt_ctrl.sv */
module cidt_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic                  entry_kind,
    input  logic [63:0]           content_hash,
    input  logic [31:0]           source_crc,
    input  logic [63:0]           source_size,
    input  logic [7:0]            target_index,
    input  logic [7:0]            record_number,
    input  logic [cidt_pkg::CAP_W-1:0] capacity,
    output cidt_pkg::store_cmd_t  cmd,
    input  cidt_pkg::ident_t      id_rdata,
    input  logic [7:0]            ord_rdata,
    output logic                  res_valid,
    input  logic                  res_ready,
    output cidt_pkg::result_t     res
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_BIND = 4'b0100,
        S_PUSH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   pend_idx_reg, pend_idx_next;
    cidt_pkg::ident_t   req_id_reg, req_id_next;
    logic [7:0]         target_reg, target_next;
    logic [7:0]         record_reg, record_next;
    cidt_pkg::result_t  res_reg, res_next;

    logic [7:0]         eff_cap;
    logic               accept;
    logic               match;

    assign eff_cap = (8'(capacity) > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH) : 8'(capacity);
    assign accept  = in_valid && (state_reg == S_IDLE);
    assign match   = pend_reg && (id_rdata == req_id_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_PUSH);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        req_id_next   = req_id_reg;
        target_next   = target_reg;
        record_next   = record_reg;
        res_next      = res_reg;

        cmd           = '0;
        cmd.rd_addr   = 8'(ptr_reg);
        cmd.wr_addr   = 8'(fill_reg);
        cmd.id_wdata  = req_id_reg;
        cmd.ord_wdata = cidt_pkg::ORDINAL_UNSET;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.rd_addr = target_index;
                if (accept)
                begin
                    req_id_next = '{kind: entry_kind, hash: content_hash,
                                    crc: source_crc, size: source_size};
                    target_next = target_index;
                    record_next = record_number;
                    res_next    = '0;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    if (req_type == cidt_pkg::REQ_LOOKUP)
                    begin
                        if (source_size == 64'd0)
                        begin
                            res_next.status = cidt_pkg::ST_INVALID;
                            state_next      = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if ((target_index >= 8'(fill_reg)) ||
                             (record_number >= 8'(TABLE_DEPTH)))
                    begin
                        res_next.status = cidt_pkg::ST_INVALID;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        // Entry read issued this cycle, data ready in S_BIND
                        state_next = S_BIND;
                    end
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    res_next.status      = cidt_pkg::ST_OK;
                    res_next.was_hit     = 1'b1;
                    res_next.found_index = 6'(pend_idx_reg);
                    pend_next            = 1'b0;
                    state_next           = S_PUSH;
                end
                else if (ptr_reg < fill_reg)
                begin
                    // Issue the next entry read; compare it next cycle
                    ptr_next      = ptr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (8'(fill_reg) >= eff_cap)
                    begin
                        res_next.status = cidt_pkg::ST_LIMIT;
                    end
                    else
                    begin
                        cmd.id_we            = 1'b1;
                        cmd.ord_we           = 1'b1;
                        fill_next            = fill_reg + 1'b1;
                        res_next.status      = cidt_pkg::ST_OK;
                        res_next.found_index = 6'(fill_reg);
                    end
                    state_next = S_PUSH;
                end
            end

            S_BIND:
            begin
                cmd.wr_addr   = target_reg;
                cmd.ord_wdata = record_reg;
                if (id_rdata.kind != cidt_pkg::KIND_RASTER)
                begin
                    res_next.status = cidt_pkg::ST_MALFORMED;
                end
                else if (ord_rdata == cidt_pkg::ORDINAL_UNSET)
                begin
                    cmd.ord_we                = 1'b1;
                    res_next.status           = cidt_pkg::ST_OK;
                    res_next.canonical_record = record_reg[5:0];
                end
                else if (ord_rdata > record_reg)
                begin
                    res_next.status = cidt_pkg::ST_MALFORMED;
                end
                else
                begin
                    res_next.status           = cidt_pkg::ST_OK;
                    res_next.canonical_record = ord_rdata[5:0];
                end
                state_next = S_PUSH;
            end

            S_PUSH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        req_id_reg   <= req_id_next;
        target_reg   <= target_next;
        record_reg   <= record_next;
        res_reg      <= res_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == CNT_W'($past(fill_reg) + 1'b1)))
        else $error("fill count moved by other than one");

    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.id_we |-> ((8'(fill_reg) < eff_cap) && (cmd.wr_addr == 8'(fill_reg))))
        else $error("insert outside free slot or capacity");

    a_hit_filled: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && match) |-> (pend_idx_reg < fill_reg))
        else $error("hit on an unfilled entry");

endmodule

/* rtl/content_identity_dedupe_table_unit.sv */
// Content identity dedupe table. A lookup request (req_type 0) scans the filled
// entries in index order for one with the same kind, hash, CRC and size and
// returns its index with was_hit set; on a miss it appends the identity with no
// bound ordinal, or returns limit exceeded once the fill count reaches
// min(table_capacity, TABLE_DEPTH). A zero source_size is an invalid argument.
// A bind request (req_type 1) attaches record_number to a raster entry on first
// use and returns the canonical ordinal; a smaller later ordinal or a non-raster
// entry is malformed, an index not below the fill count or an ordinal not below
// TABLE_DEPTH is invalid. Reset empties the table. Rate: one request at a time.
// A lookup scans one entry per cycle through the read port of the entry memory
// and compares each registered read the cycle after; a bind does one memory
// read, and a request rejected up front goes straight to the result. The next
// request is taken the cycle after the result moves to the output register,
// even while that result is still stalled. table_capacity is written over the
// APB port at byte address 0; the user must do so only while the block is idle,
// as the block itself does not enforce it.
module content_identity_dedupe_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // Request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic        entry_kind,
    input  logic [63:0] content_hash,
    input  logic [31:0] source_crc,
    input  logic [63:0] source_size,
    input  logic [7:0]  target_index,
    input  logic [7:0]  record_number,

    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        was_hit,
    output logic [5:0]  found_index,
    output logic [5:0]  canonical_record,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_CAPACITY = 1'b0;

    logic [cidt_pkg::CAP_W-1:0] capacity_reg;
    logic                       out_valid_reg;
    cidt_pkg::result_t          out_res_reg;

    cidt_pkg::store_cmd_t       cmd;
    cidt_pkg::ident_t           id_rdata;
    logic [7:0]                 ord_rdata;
    logic                       res_valid;
    logic                       res_ready;
    cidt_pkg::result_t          res;
    logic                       cfg_write;

    // Configuration register: zero-wait APB, capacity at word 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cidt_pkg::CAP_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[cidt_pkg::CAP_W-1:0];
        end
    end

    // Entry memories: identity and bound ordinal, registered read
    cidt_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk           (clk),
        .cmd           (cmd),
        .id_rdata_reg  (id_rdata),
        .ord_rdata_reg (ord_rdata)
    );

    // Scan and bind sequencer with fill count
    cidt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .entry_kind    (entry_kind),
        .content_hash  (content_hash),
        .source_crc    (source_crc),
        .source_size   (source_size),
        .target_index  (target_index),
        .record_number (record_number),
        .capacity      (capacity_reg),
        .cmd           (cmd),
        .id_rdata      (id_rdata),
        .ord_rdata     (ord_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Output register: hold the result while stalled, take a new one once free
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_res_reg.status;
    assign was_hit          = out_res_reg.was_hit;
    assign found_index      = out_res_reg.found_index;
    assign canonical_record = out_res_reg.canonical_record;

endmodule
